// ----- rtl/rmbp_pkg.sv -----
// Package for the multi-bulk request parser: widths, character codes,
// parser phase, result kinds, error codes and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package rmbp_pkg;

  localparam int REG_W = 31;
  localparam int NUMBER_WIDTH_DEF = 31;
  localparam int CFG_INDEX_W = 1;
  localparam int TDATA_OUT_W = 48;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_ARG_COUNT  = 1'b0,
    CFG_MAX_ARG_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DISCARD = 3'd1,
    PH_COUNT   = 3'd2,
    PH_DOLLAR  = 3'd3,
    PH_LEN     = 3'd4,
    PH_DATA    = 3'd5,
    PH_CR      = 3'd6,
    PH_LF      = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_ARG_DONE  = 2'd1,
    KIND_EMPTY_CMD = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_START   = 3'd0,
    ERR_BAD_COUNT   = 3'd1,
    ERR_NO_DOLLAR   = 3'd2,
    ERR_BAD_LENGTH  = 3'd3,
    ERR_NO_CRLF     = 3'd4
  } err_t;

  // code field value on results that are not errors
  localparam logic [2:0] ERR_NONE = 3'd0;

  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] byte_in;
  } num_ctl_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic [REG_W-1:0] arg_index;
    logic       done;
    err_t       code;
  } result_t;

endpackage

// ----- rtl/rmbp_number.sv -----
// Decimal number accumulator for the count and length lines.
// Tracks sign, digits, overflow, trailing text and CR LF detection.
// Depends on rmbp_pkg.
`timescale 1ns / 1ps

module rmbp_number import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  num_ctl_t                ctl,
  input  logic [REG_W-1:0]        limit,
  output logic                    line_end,
  output logic                    num_ok,
  output logic                    num_zero,
  output logic [NUMBER_WIDTH-1:0] value
);

  localparam int PW = NUMBER_WIDTH + 4;

  logic overflow, negative, digits_seen, trailing, pending_cr;
  logic [NUMBER_WIDTH-1:0] value_next;
  logic overflow_next, negative_next, digits_next, trailing_next, pending_next;
  logic trail_eff, is_digit;
  logic [PW-1:0] ext, prod;

  assign line_end = pending_cr && (ctl.byte_in == CH_LF);
  assign num_zero = (value == '0);
  assign num_ok   = digits_seen && !overflow && !(negative && !num_zero)
                    && (REG_W'(value) <= limit);

  assign is_digit = (ctl.byte_in >= CH_ZERO) && (ctl.byte_in <= CH_NINE);
  assign ext      = PW'(value);
  assign prod     = (ext << 3) + (ext << 1) + PW'(ctl.byte_in[3:0]);

  always_comb begin
    value_next    = value;
    overflow_next = overflow;
    negative_next = negative;
    digits_next   = digits_seen;
    trailing_next = trailing;
    pending_next  = pending_cr;
    trail_eff     = trailing || pending_cr;
    if (ctl.clear) begin
      value_next    = '0;
      overflow_next = 1'b0;
      negative_next = 1'b0;
      digits_next   = 1'b0;
      trailing_next = 1'b0;
      pending_next  = 1'b0;
    end else if (ctl.feed && !line_end) begin
      // a lone CR counts as text
      trailing_next = trail_eff;
      pending_next  = 1'b0;
      if (ctl.byte_in == CH_CR) begin
        pending_next = 1'b1;
      end else if (!trail_eff) begin
        if (is_digit) begin
          digits_next = 1'b1;
          if (|prod[PW-1:NUMBER_WIDTH]) begin
            overflow_next = 1'b1;
            value_next    = '1;
          end else begin
            value_next = prod[NUMBER_WIDTH-1:0];
          end
        end else if (ctl.byte_in == CH_MINUS && !digits_seen && !negative) begin
          negative_next = 1'b1;
        end else begin
          trailing_next = 1'b1;
        end
      end
    end else if (ctl.feed) begin
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value       <= '0;
      overflow    <= 1'b0;
      negative    <= 1'b0;
      digits_seen <= 1'b0;
      trailing    <= 1'b0;
      pending_cr  <= 1'b0;
    end else begin
      value       <= value_next;
      overflow    <= overflow_next;
      negative    <= negative_next;
      digits_seen <= digits_next;
      trailing    <= trailing_next;
      pending_cr  <= pending_next;
    end
  end

endmodule

// ----- rtl/rmbp_ctrl.sv -----
// Parser sequencer: phase, argument and byte counters, result formation.
// Depends on rmbp_pkg; drives rmbp_number through num_ctl_t.
`timescale 1ns / 1ps

module rmbp_ctrl import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              byte_in,
  input  logic [REG_W-1:0]        max_arg_count,
  input  logic [REG_W-1:0]        max_arg_length,
  input  logic                    line_end,
  input  logic                    num_ok,
  input  logic                    num_zero,
  input  logic [NUMBER_WIDTH-1:0] value,
  output num_ctl_t                num_ctl,
  output logic [REG_W-1:0]        limit,
  output result_t                 result
);

  phase_t phase, phase_next;
  logic [NUMBER_WIDTH-1:0] args_left, args_left_next;
  logic [NUMBER_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [NUMBER_WIDTH-1:0] current_arg, current_arg_next;
  logic [NUMBER_WIDTH-1:0] bytes_dec;
  logic last_arg;

  assign limit     = (phase == PH_COUNT) ? max_arg_count : max_arg_length;
  assign bytes_dec = bytes_left - NUMBER_WIDTH'(1);
  assign last_arg  = (args_left <= NUMBER_WIDTH'(1));

  always_comb begin
    phase_next       = phase;
    args_left_next   = args_left;
    bytes_left_next  = bytes_left;
    current_arg_next = current_arg;
    num_ctl.clear    = 1'b0;
    num_ctl.feed     = 1'b0;
    num_ctl.byte_in  = byte_in;
    result           = '0;
    result.arg_index = REG_W'(current_arg);
    case (phase)
      PH_IDLE, PH_DISCARD: begin
        if (byte_in == CH_STAR) begin
          num_ctl.clear = step;
          phase_next    = PH_COUNT;
        end else if (phase == PH_IDLE) begin
          phase_next       = PH_DISCARD;
          result.valid     = step;
          result.kind      = KIND_ERROR;
          result.code      = ERR_BAD_START;
          result.arg_index = '0;
        end
      end
      PH_COUNT: begin
        num_ctl.feed = step;
        if (line_end) begin
          if (!num_ok) begin
            phase_next       = PH_DISCARD;
            result.valid     = step;
            result.kind      = KIND_ERROR;
            result.code      = ERR_BAD_COUNT;
            result.arg_index = '0;
          end else if (num_zero) begin
            phase_next       = PH_IDLE;
            result.valid     = step;
            result.kind      = KIND_EMPTY_CMD;
            result.done      = 1'b1;
            result.arg_index = '0;
          end else begin
            args_left_next   = value;
            current_arg_next = '0;
            phase_next       = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (byte_in != CH_DOLLAR) begin
          phase_next   = PH_DISCARD;
          result.valid = step;
          result.kind  = KIND_ERROR;
          result.code  = ERR_NO_DOLLAR;
        end else begin
          num_ctl.clear = step;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        num_ctl.feed = step;
        if (line_end) begin
          if (!num_ok) begin
            phase_next   = PH_DISCARD;
            result.valid = step;
            result.kind  = KIND_ERROR;
            result.code  = ERR_BAD_LENGTH;
          end else begin
            bytes_left_next = value;
            phase_next      = num_zero ? PH_CR : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next  = bytes_dec;
        if (bytes_dec == '0) begin
          phase_next = PH_CR;
        end
        result.valid     = step;
        result.kind      = KIND_DATA;
        result.data_byte = byte_in;
      end
      PH_CR: begin
        if (byte_in != CH_CR) begin
          phase_next   = PH_DISCARD;
          result.valid = step;
          result.kind  = KIND_ERROR;
          result.code  = ERR_NO_CRLF;
        end else begin
          phase_next = PH_LF;
        end
      end
      PH_LF: begin
        if (byte_in != CH_LF) begin
          phase_next   = PH_DISCARD;
          result.valid = step;
          result.kind  = KIND_ERROR;
          result.code  = ERR_NO_CRLF;
        end else begin
          args_left_next   = last_arg ? '0 : args_left - NUMBER_WIDTH'(1);
          current_arg_next = current_arg + NUMBER_WIDTH'(1);
          phase_next       = last_arg ? PH_IDLE : PH_DOLLAR;
          result.valid     = step;
          result.kind      = KIND_ARG_DONE;
          result.done      = last_arg;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      args_left   <= '0;
      bytes_left  <= '0;
      current_arg <= '0;
    end else if (step) begin
      phase       <= phase_next;
      args_left   <= args_left_next;
      bytes_left  <= bytes_left_next;
      current_arg <= current_arg_next;
    end
  end

endmodule

// ----- rtl/rmbp_out_reg.sv -----
// Output register for the result stream; holds one result while the
// receiver stalls and reloads in the same cycle it is taken.
// Depends on rmbp_pkg.
`timescale 1ns / 1ps

module rmbp_out_reg import rmbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  result_t din,
  output logic    space,
  output logic    valid,
  input  logic    take,
  output result_t dout
);

  assign space = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && din.valid) begin
      dout <= din;
    end
  end

endmodule

// ----- rtl/resp_multibulk_request_parser_top.sv -----
// Multi-bulk request parser: s_axis byte input, m_axis result output,
// configuration write channel with the two limit registers.
// Depends on rmbp_pkg, rmbp_number, rmbp_ctrl, rmbp_out_reg.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one request byte per transaction in s_axis_tdata.
//   m_axis carries zero or one result per input byte: data byte, argument
//   complete, empty command complete or error. tuser holds the kind, tlast
//   marks the result that completes the command.
//   cfg writes max_arg_count (index 0) or max_arg_length (index 1); cfg_ready
//   is always high. Write only while the parser is idle.
// Output: a result is registered and appears on m_axis in the cycle after its input byte is taken.
// Throughput: one byte per cycle while the output register has space; the parser state and the output register
//   update in the same cycle the byte is taken.
// Reset: rst clears the phase and counters, both limits go to 2^31-1 and
//   m_axis_tvalid drops. The parser waits for a '*'.
// Stall: while a result waits on m_axis, s_axis_tready follows m_axis_tready,
//   so a byte is still taken in the cycle the waiting result leaves.
module resp_multibulk_request_parser_top import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_byte, [38:8] arg_index, [41:39] error_code, [47:42] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser,   // [1:0] out_kind
  output logic                   m_axis_tlast,   // command_done
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  logic [REG_W-1:0] max_arg_count, max_arg_length, limit;
  logic step, space, line_end, num_ok, num_zero;
  logic [NUMBER_WIDTH-1:0] value;
  num_ctl_t num_ctl;
  result_t  res, res_q;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = space;
  assign step          = s_axis_tvalid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count  <= '1;
      max_arg_length <= '1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MAX_ARG_COUNT:  max_arg_count  <= cfg_data;
        CFG_MAX_ARG_LENGTH: max_arg_length <= cfg_data;
        default: ;
      endcase
    end
  end

  rmbp_number #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_number (
    .clk      (clk),
    .rst      (rst),
    .ctl      (num_ctl),
    .limit    (limit),
    .line_end (line_end),
    .num_ok   (num_ok),
    .num_zero (num_zero),
    .value    (value)
  );

  rmbp_ctrl #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .byte_in        (s_axis_tdata),
    .max_arg_count  (max_arg_count),
    .max_arg_length (max_arg_length),
    .line_end       (line_end),
    .num_ok         (num_ok),
    .num_zero       (num_zero),
    .value          (value),
    .num_ctl        (num_ctl),
    .limit          (limit),
    .result         (res)
  );

  rmbp_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .din   (res),
    .space (space),
    .valid (m_axis_tvalid),
    .take  (m_axis_tready),
    .dout  (res_q)
  );

  assign m_axis_tdata = TDATA_OUT_W'({res_q.code, res_q.arg_index, res_q.data_byte});
  assign m_axis_tuser = res_q.kind;
  assign m_axis_tlast = res_q.done;

endmodule

// ----- tb/sv/resp_multibulk_request_parser_top_tb.sv -----
// Self-checking testbench for resp_multibulk_request_parser_top: byte stream in,
// parse results out, checked against an in-bench model of the parser.
// Depends on rmbp_pkg and the parser RTL.
`timescale 1ns / 1ps

module resp_multibulk_request_parser_top_tb;
  import rmbp_pkg::*;

  localparam int     IDLE_PCT    = 7;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint NUM_MAX     = (longint'(1) << NUMBER_WIDTH_DEF) - 1;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [REG_W-1:0] idx;
    logic             done;
    logic [2:0]       code;
  } parse_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]       cfg_data = '0;

  resp_multibulk_request_parser_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and expectation stores
  logic [7:0]    pend[$];
  logic [7:0]    cmd_buf[$];
  parse_result_t want_q[$];

  bit quiet      = 1'b0;
  bit hold_armed = 1'b0;
  int hold_cnt   = 0;
  bit in_acc     = 1'b0;
  int fails      = 0;
  int taken      = 0;
  int cyc        = 0;
  int seen_kind[4];

  // parser model state
  logic [REG_W-1:0] lim_count = REG_W'(NUM_MAX);
  logic [REG_W-1:0] lim_len   = REG_W'(NUM_MAX);
  phase_t           ph        = PH_IDLE;
  logic [REG_W-1:0] nval      = '0;
  bit nvof, nneg, ndig, ntrail, ncr;
  logic [REG_W-1:0] args_left = '0;
  logic [REG_W-1:0] bytes_left = '0;
  logic [REG_W-1:0] cur_arg = '0;

  function void line_reset();
    nval = '0;
    nvof = 0;
    nneg = 0;
    ndig = 0;
    ntrail = 0;
    ncr = 0;
  endfunction

  function void line_text(logic [7:0] c);
    longint v;
    if (ntrail) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = longint'(nval) * 10 + longint'(c - CH_ZERO);
      if (v > NUM_MAX) begin
        nvof = 1;
        nval = REG_W'(NUM_MAX);
      end else begin
        nval = REG_W'(v);
      end
      ndig = 1;
    end else if (c == CH_MINUS && !ndig && !nneg) begin
      nneg = 1;
    end else begin
      ntrail = 1;
    end
  endfunction

  // true when this byte closes the CR LF ending the number line
  function bit line_feed(logic [7:0] b);
    if (ncr) begin
      ncr = 0;
      if (b == CH_LF) return 1;
      line_text(CH_CR);
    end
    if (b == CH_CR) ncr = 1;
    else line_text(b);
    return 0;
  endfunction

  function bit line_ok(logic [REG_W-1:0] lim);
    return ndig && !nvof && !(nneg && nval != 0) && nval <= lim;
  endfunction

  function void note(kind_t k, logic [7:0] d, logic [REG_W-1:0] i, logic dn, logic [2:0] c);
    parse_result_t r;
    r.kind = k;
    r.data = d;
    r.idx  = i;
    r.done = dn;
    r.code = c;
    want_q.push_back(r);
  endfunction

  function void reject(logic [2:0] c, logic [REG_W-1:0] i);
    ph = PH_DISCARD;
    note(KIND_ERROR, 8'h00, i, 1'b0, c);
  endfunction

  function void parse_byte(logic [7:0] b);
    bit last;
    case (ph)
      PH_IDLE, PH_DISCARD: begin
        if (b == CH_STAR) begin
          line_reset();
          ph = PH_COUNT;
        end else if (ph == PH_IDLE) begin
          reject(ERR_BAD_START, '0);
        end
      end
      PH_COUNT: begin
        if (line_feed(b)) begin
          if (!line_ok(lim_count)) begin
            reject(ERR_BAD_COUNT, '0);
          end else if (nval == 0) begin
            ph = PH_IDLE;
            note(KIND_EMPTY_CMD, 8'h00, '0, 1'b1, ERR_NONE);
          end else begin
            args_left = nval;
            cur_arg = '0;
            ph = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          reject(ERR_NO_DOLLAR, cur_arg);
        end else begin
          line_reset();
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (line_feed(b)) begin
          if (!line_ok(lim_len)) begin
            reject(ERR_BAD_LENGTH, cur_arg);
          end else begin
            bytes_left = nval;
            ph = (nval == 0) ? PH_CR : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) ph = PH_CR;
        note(KIND_DATA, b, cur_arg, 1'b0, ERR_NONE);
      end
      PH_CR: begin
        if (b != CH_CR) reject(ERR_NO_CRLF, cur_arg);
        else ph = PH_LF;
      end
      PH_LF: begin
        if (b != CH_LF) begin
          reject(ERR_NO_CRLF, cur_arg);
        end else begin
          last = (args_left <= 1);
          note(KIND_ARG_DONE, 8'h00, cur_arg, last, ERR_NONE);
          args_left = last ? '0 : args_left - 1'b1;
          cur_arg = cur_arg + 1'b1;
          ph = last ? PH_IDLE : PH_DOLLAR;
        end
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  function void cmp(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  // request byte builders
  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) cmd_buf.push_back(s[i]);
  endfunction

  function void add_crlf();
    cmd_buf.push_back(CH_CR);
    cmd_buf.push_back(CH_LF);
  endfunction

  // number line with occasional sign or trailing-text dressing
  function void add_line(int n);
    int pick;
    pick = $urandom_range(11);
    if ((pick == 0 && n == 0) || pick == 3) add_text("-");
    add_text($sformatf("%0d", n));
    if (pick == 1) begin
      add_text(" ok");
    end else if (pick == 2) begin
      cmd_buf.push_back(CH_CR);
      add_text("q");
    end
    add_crlf();
  endfunction

  function void send();
    foreach (cmd_buf[i]) pend.push_back(cmd_buf[i]);
    cmd_buf.delete();
  endfunction

  // mostly well-formed commands; some corrupted, truncated or plain noise
  function int gen_command(int max_n, int max_len);
    int n, len, mode, pos, cnt;
    mode = $urandom_range(99);
    if (mode >= 92) begin
      repeat ($urandom_range(1, 6)) cmd_buf.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(max_n);
      cmd_buf.push_back(CH_STAR);
      add_line(n);
      for (int a = 0; a < n; a++) begin
        len = $urandom_range(max_len);
        cmd_buf.push_back(CH_DOLLAR);
        add_line(len);
        repeat (len) cmd_buf.push_back(8'($urandom_range(255)));
        add_crlf();
      end
      if (mode >= 78) begin
        pos = $urandom_range(cmd_buf.size() - 1);
        cmd_buf[pos] = 8'($urandom_range(255));
        if (mode >= 86) while (cmd_buf.size() > pos + 1) void'(cmd_buf.pop_back());
      end
    end
    cnt = cmd_buf.size();
    send();
    return cnt;
  endfunction

  task automatic settle();
    while (pend.size() != 0 || s_axis_tvalid || want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(cfg_reg_t idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_ARG_COUNT) lim_count = val;
    else lim_len = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int bytes, int max_n, int max_len);
    int made;
    made = 0;
    while (made < bytes) made += gen_command(max_n, max_len);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_acc) begin
      if (pend.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        s_axis_tdata  <= pend.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off once armed
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_armed && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    parse_result_t w;
    in_acc = !rst && s_axis_tvalid && s_axis_tready;
    if (in_acc) begin
      parse_byte(s_axis_tdata);
      taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_kind[m_axis_tuser]++;
      if (want_q.size() == 0) begin
        $error("result with no expectation: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        w = want_q.pop_front();
        // tdata: [7:0] out_byte, [38:8] arg_index, [41:39] error_code
        cmp("out_kind", w.kind, m_axis_tuser);
        cmp("out_byte", w.data, m_axis_tdata[7:0]);
        cmp("arg_index", w.idx, m_axis_tdata[38:8]);
        cmp("command_done", w.done, m_axis_tlast);
        cmp("error_code", w.code, m_axis_tdata[41:39]);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cyc, want_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty commands, full command, each error, number corner cases
    add_text("*0"); add_crlf();
    add_text("*-0"); add_crlf();
    add_text("*2"); add_crlf(); add_text("$3"); add_crlf();
    cmd_buf.push_back(8'h00); cmd_buf.push_back(8'hFF); cmd_buf.push_back(CH_STAR); add_crlf();
    add_text("$0"); add_crlf(); add_crlf();
    add_text("#ab");
    add_text("*"); add_crlf();
    add_text("*-1"); add_crlf();
    add_text("*2147483648"); add_crlf();
    add_text("*1"); cmd_buf.push_back(CH_CR); add_text("7 "); add_crlf();
    add_text("$1"); add_crlf(); add_text("Z"); add_crlf();
    add_text("*1"); add_crlf(); add_text("*x");
    add_text("*1"); add_crlf(); add_text("$x"); add_crlf();
    add_text("*1"); add_crlf(); add_text("$2147483648"); add_crlf();
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf(); add_text("qX");
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf(); add_text("q");
    cmd_buf.push_back(CH_CR); add_text("Y");
    add_text("*2147483647"); add_crlf(); add_text("!");
    add_text("*1");
    send();
    settle();

    // count limit lowered while the count line is still open
    write_limit(CFG_MAX_ARG_COUNT, '0);
    add_crlf();
    add_text("*0"); add_crlf();
    add_text("*1"); add_crlf();
    send();
    settle();
    write_limit(CFG_MAX_ARG_COUNT, 31'd1);
    write_limit(CFG_MAX_ARG_LENGTH, '0);
    add_text("*1"); add_crlf(); add_text("$0"); add_crlf(); add_crlf();
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf();
    send();
    settle();

    // small limits, no idling on either side
    write_limit(CFG_MAX_ARG_COUNT, 31'd3);
    write_limit(CFG_MAX_ARG_LENGTH, 31'd5);
    quiet = 1'b1;
    random_phase(200, 4, 6);
    settle();
    quiet = 1'b0;

    // widest limits, with the receiver holding off for a long stretch
    write_limit(CFG_MAX_ARG_COUNT, REG_W'(NUM_MAX));
    write_limit(CFG_MAX_ARG_LENGTH, REG_W'(NUM_MAX));
    random_phase(200, 4, 10);
    hold_armed = 1'b1;
    settle();

    write_limit(CFG_MAX_ARG_COUNT, 31'd2);
    write_limit(CFG_MAX_ARG_LENGTH, 31'd1);
    random_phase(200, 3, 2);
    settle();

    $display("parsed %0d request bytes over limit settings from 0 to 2^31-1", taken);
    $display("results: %0d data, %0d arg done, %0d empty cmd, %0d error",
             seen_kind[KIND_DATA], seen_kind[KIND_ARG_DONE], seen_kind[KIND_EMPTY_CMD],
             seen_kind[KIND_ERROR]);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- resp_multibulk_request_parser_top.f -----
rtl/rmbp_pkg.sv
rtl/rmbp_number.sv
rtl/rmbp_ctrl.sv
rtl/rmbp_out_reg.sv
rtl/resp_multibulk_request_parser_top.sv
tb/sv/resp_multibulk_request_parser_top_tb.sv
